@@ hw/rtl/rlrd_pkg.sv @@
// shared types and constants of the rgb led ramp dimmer
package rlrd_pkg;

  localparam int LVL_W     = 8;
  localparam int CFG_IDX_W = 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DELAY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTENSITY = 1'b1;

  // ramp codes with a meaning of their own
  localparam logic [LVL_W-1:0] RAMP_CODE_JUMP    = 8'd0;
  localparam logic [LVL_W-1:0] RAMP_CODE_DEFAULT = 8'd255;

  localparam logic [LVL_W-1:0] DELAY_MAX     = 8'd254;
  localparam logic [LVL_W-1:0] DELAY_RST     = 8'd5;
  localparam logic [LVL_W-1:0] MIN_INT_RST   = 8'd13;
  localparam logic [LVL_W-1:0] TICKS_SAT     = 8'd255;

  // 255 * 255 and its scaled reciprocal floor(2^32 / 65025)
  localparam logic [16:0] FULL_SQ     = 17'd65025;
  localparam int          RECIP_W     = 17;
  localparam logic [16:0] RECIP       = 17'd66051;
  localparam int          RECIP_SHIFT = 32;

  typedef struct packed {
    logic             fire;
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } upd_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_rcp;
  } stage_ld_t;

endpackage

@@ hw/rtl/rlrd_ramp_ctrl.sv @@
// tick counting, set command capture and intensity ramp step
module rlrd_ramp_ctrl
  import rlrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             op_set,
  input  logic [LVL_W-1:0] target_level,
  input  logic [LVL_W-1:0] red_weight,
  input  logic [LVL_W-1:0] green_weight,
  input  logic [LVL_W-1:0] blue_weight,
  input  logic [LVL_W-1:0] ramp_code,
  input  logic [LVL_W-1:0] default_ramp_delay,
  input  logic [LVL_W-1:0] min_intensity,
  output upd_t             upd
);

  logic [LVL_W-1:0] goal_r, goal_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic [LVL_W-1:0] red_r, red_nxt;
  logic [LVL_W-1:0] green_r, green_nxt;
  logic [LVL_W-1:0] blue_r, blue_nxt;
  logic             ramping_r, ramping_nxt;
  logic [LVL_W-1:0] delay_r, delay_nxt;
  logic [LVL_W-1:0] ticks_r, ticks_nxt;
  logic             fire_r;

  logic [LVL_W-1:0] ticks_upd;
  logic [LVL_W-1:0] dflt_delay;
  logic [LVL_W-1:0] stepped;
  logic [LVL_W-1:0] clamped;
  logic             fire;

  always_comb begin
    dflt_delay = (default_ramp_delay > DELAY_MAX) ? DELAY_MAX : default_ramp_delay;

    if (op_set) begin
      ticks_upd   = ticks_r;
      goal_nxt    = target_level;
      red_nxt     = red_weight;
      green_nxt   = green_weight;
      blue_nxt    = blue_weight;
      ramping_nxt = (ramp_code != RAMP_CODE_JUMP);
      delay_nxt   = (ramp_code == RAMP_CODE_DEFAULT) ? dflt_delay : ramp_code;
    end else begin
      ticks_upd   = (ticks_r == TICKS_SAT) ? ticks_r : ticks_r + 8'd1;
      goal_nxt    = goal_r;
      red_nxt     = red_r;
      green_nxt   = green_r;
      blue_nxt    = blue_r;
      ramping_nxt = ramping_r;
      delay_nxt   = delay_r;
    end

    fire = (ticks_upd > delay_nxt);

    if (!ramping_nxt) begin
      stepped = goal_nxt;
    end else if (level_r < goal_nxt) begin
      stepped = level_r + 8'd1;
    end else if (level_r > goal_nxt) begin
      stepped = level_r - 8'd1;
    end else begin
      stepped = level_r;
    end

    // hold a lit led at the floor level while the goal is on
    if (goal_nxt != '0 && stepped != '0 && stepped < min_intensity) begin
      clamped = min_intensity;
    end else begin
      clamped = stepped;
    end

    level_nxt = fire ? clamped : level_r;
    ticks_nxt = fire ? '0 : ticks_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_r    <= '0;
      level_r   <= '0;
      red_r     <= '0;
      green_r   <= '0;
      blue_r    <= '0;
      ramping_r <= 1'b0;
      delay_r   <= DELAY_RST;
      ticks_r   <= '0;
    end else if (accept) begin
      goal_r    <= goal_nxt;
      level_r   <= level_nxt;
      red_r     <= red_nxt;
      green_r   <= green_nxt;
      blue_r    <= blue_nxt;
      ramping_r <= ramping_nxt;
      delay_r   <= delay_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fire_r <= fire;
    end
  end

  assign upd.fire  = fire_r;
  assign upd.level = level_r;
  assign upd.red   = red_r;
  assign upd.green = green_r;
  assign upd.blue  = blue_r;

  a_fire_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fire |=> ticks_r == '0)
    else $error("tick count not cleared after update");

  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !op_set && !fire |=> ticks_r != '0)
    else $error("tick without update left count at zero");

  a_level_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(level_r) && $stable(ticks_r))
    else $error("ramp state moved without a transaction");

endmodule

@@ hw/rtl/rlrd_duty_scale.sv @@
// one channel: level times weight scaled to a pwm duty over two register stages
module rlrd_duty_scale
  import rlrd_pkg::*;
#(
  parameter int DUTY_BITS = 8
) (
  input  logic                 clk,
  input  stage_ld_t            ld,
  input  logic [LVL_W-1:0]     level,
  input  logic [LVL_W-1:0]     weight,
  output logic [DUTY_BITS-1:0] duty
);

  localparam int XW = 2 * LVL_W;
  localparam int YW = XW + DUTY_BITS;
  localparam int PW = YW + RECIP_W;
  localparam int QW = PW - RECIP_SHIFT;

  logic [XW-1:0]   x;
  logic [YW-1:0]   y_nxt;
  logic [YW-1:0]   y_r;
  logic [YW-1:0]   yq_r;
  logic [PW-1:0]   prod;
  logic [QW-1:0]   q0_r;
  logic [YW:0]     qd;
  logic [YW:0]     rem;
  logic [QW-1:0]   q_fix;

  // y = level * weight * (2^DUTY_BITS - 1)
  always_comb begin
    x     = XW'(level) * XW'(weight);
    y_nxt = (YW'(x) << DUTY_BITS) - YW'(x);
  end

  always_ff @(posedge clk) begin
    if (ld.ld_mul) begin
      y_r <= y_nxt;
    end
  end

  assign prod = PW'(y_r) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (ld.ld_rcp) begin
      yq_r <= y_r;
      q0_r <= prod[PW-1:RECIP_SHIFT];
    end
  end

  // estimate is exact or one low
  always_comb begin
    qd    = (YW+1)'(q0_r) * (YW+1)'(FULL_SQ);
    rem   = {1'b0, yq_r} - qd;
    q_fix = (rem >= (YW+1)'(FULL_SQ)) ? q0_r + QW'(1) : q0_r;
    duty  = q_fix[DUTY_BITS-1:0];
  end

endmodule

@@ hw/rtl/rgb_led_ramp_dimmer.sv @@
// top level of the rgb led dimmer with linear intensity ramp
//
// Accepts one transaction per clock, a tick or a set command, and returns one result
// per transaction in the same order. The ramp/tick state update is a loop that
// registers the new intensity, then each colour channel passes a level*weight
// multiply stage, a reciprocal-multiply stage for the divide by 255*255, and a
// correction step feeding the output register. Stages collapse bubbles, so input
// is still taken while a result waits on out_tready until the pipeline is full.
// Configuration writes land at once and should be issued only with no transaction in
// flight. No clearing pass after reset.
module rgb_led_ramp_dimmer
  import rlrd_pkg::*;
#(
  parameter int DUTY_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_tvalid,
  output logic                      in_tready,
  // target_level, red_weight, green_weight, blue_weight, ramp_code
  input  logic [5*LVL_W-1:0]        in_tdata,
  // operation
  input  logic                      in_tuser,

  output logic                      out_tvalid,
  input  logic                      out_tready,
  // red_duty, green_duty, blue_duty, zero fill
  output logic [((3*DUTY_BITS+7)/8)*8-1:0] out_tdata,
  // changed
  output logic                      out_tuser,

  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [LVL_W-1:0]          cfg_wdata
);

  localparam int DUTY_SUM = 3 * DUTY_BITS;
  localparam int OUT_W    = ((DUTY_SUM + 7) / 8) * 8;

  logic [LVL_W-1:0] dflt_delay_r;
  logic [LVL_W-1:0] min_int_r;

  logic      accept;
  logic      adv1, adv2, adv3, adv4;
  logic      v1_r, v2_r, v3_r;
  logic      out_valid_r;
  logic      fire2_r, fire3_r;
  upd_t      upd;
  stage_ld_t ld;

  logic [DUTY_BITS-1:0] duty_red, duty_green, duty_blue;
  logic [DUTY_SUM-1:0]  duty_new;
  logic [DUTY_SUM-1:0]  last_duty_r;
  logic [DUTY_SUM-1:0]  res_duty_r;
  logic                 res_changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_delay_r <= DELAY_RST;
      min_int_r    <= MIN_INT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEFAULT_DELAY: dflt_delay_r <= cfg_wdata;
        CFG_MIN_INTENSITY: min_int_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // each stage moves when empty or when the one after it moves
  always_comb begin
    adv4      = !out_valid_r || out_tready;
    adv3      = !v3_r || adv4;
    adv2      = !v2_r || adv3;
    adv1      = !v1_r || adv2;
    in_tready = adv1;
    accept    = in_tvalid && in_tready;
    ld.ld_mul = adv2 && v1_r;
    ld.ld_rcp = adv3 && v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv1) v1_r        <= in_tvalid;
      if (adv2) v2_r        <= v1_r;
      if (adv3) v3_r        <= v2_r;
      if (adv4) out_valid_r <= v3_r;
    end
  end

  rlrd_ramp_ctrl u_ramp (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (accept),
    .op_set             (in_tuser),
    .target_level       (in_tdata[LVL_W-1:0]),
    .red_weight         (in_tdata[2*LVL_W-1:LVL_W]),
    .green_weight       (in_tdata[3*LVL_W-1:2*LVL_W]),
    .blue_weight        (in_tdata[4*LVL_W-1:3*LVL_W]),
    .ramp_code          (in_tdata[5*LVL_W-1:4*LVL_W]),
    .default_ramp_delay (dflt_delay_r),
    .min_intensity      (min_int_r),
    .upd                (upd)
  );

  rlrd_duty_scale #(.DUTY_BITS(DUTY_BITS)) u_scale_red (
    .clk    (clk),
    .ld     (ld),
    .level  (upd.level),
    .weight (upd.red),
    .duty   (duty_red)
  );

  rlrd_duty_scale #(.DUTY_BITS(DUTY_BITS)) u_scale_green (
    .clk    (clk),
    .ld     (ld),
    .level  (upd.level),
    .weight (upd.green),
    .duty   (duty_green)
  );

  rlrd_duty_scale #(.DUTY_BITS(DUTY_BITS)) u_scale_blue (
    .clk    (clk),
    .ld     (ld),
    .level  (upd.level),
    .weight (upd.blue),
    .duty   (duty_blue)
  );

  assign duty_new = {duty_blue, duty_green, duty_red};

  always_ff @(posedge clk) begin
    if (ld.ld_mul) fire2_r <= upd.fire;
    if (ld.ld_rcp) fire3_r <= fire2_r;
  end

  // duties only move on an update, else the present ones are reported
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_duty_r <= '0;
    end else if (adv4 && v3_r && fire3_r) begin
      last_duty_r <= duty_new;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && v3_r) begin
      if (fire3_r) begin
        res_duty_r    <= duty_new;
        res_changed_r <= (duty_new != last_duty_r);
      end else begin
        res_duty_r    <= last_duty_r;
        res_changed_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(res_duty_r);
  assign out_tuser  = res_changed_r;

  a_no_change_without_update: assert property (@(posedge clk) disable iff (!rst_n)
    adv4 && v3_r && !fire3_r |=> !out_tuser)
    else $error("changed flag raised without an update");

  a_duties_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv4 && v3_r && fire3_r) |=> $stable(last_duty_r))
    else $error("duties moved without an update");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && v1_r && v2_r && v3_r |-> !in_tready)
    else $error("input taken while pipeline full");

endmodule

@@ verif/rlrd_tb_pkg.sv @@
// operation codes and result type shared by the dimmer testbench files
`timescale 1ns / 1ps
package rlrd_tb_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } dim_op_e;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       changed;
  } duty_res_t;

endpackage

@@ verif/dimmer_checker.sv @@
// checker that predicts the dimmer duties and compares every result transaction
`timescale 1ns / 1ps
module dimmer_checker
  import rlrd_pkg::*;
  import rlrd_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [5*LVL_W-1:0]   in_tdata,
  input  logic                 in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [23:0]          out_tdata,
  input  logic                 out_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LVL_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   checked,
  output int                   changed_seen
);

  logic [7:0] dflt_delay, min_level;
  logic [7:0] goal, level, w_red, w_green, w_blue, delay, ticks;
  logic       ramp_on;
  logic [7:0] duty_red, duty_green, duty_blue;
  duty_res_t  expected_duties[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch on %s: got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic logic [7:0] scaled_duty(input logic [7:0] lvl, input logic [7:0] w);
    logic [15:0] prod;
    prod = lvl * w;
    return 8'(prod / 16'd255);
  endfunction

  function automatic logic [7:0] effective_delay();
    return (dflt_delay > DELAY_MAX) ? DELAY_MAX : dflt_delay;
  endfunction

  function automatic duty_res_t step_dimmer(input dim_op_e op, input logic [39:0] data);
    duty_res_t  res;
    logic [7:0] code, nr, ng, nb;
    if (op == OP_TICK) begin
      if (ticks != TICKS_SAT) ticks = ticks + 8'd1;
    end else begin
      code    = data[39:32];
      goal    = data[7:0];
      w_red   = data[15:8];
      w_green = data[23:16];
      w_blue  = data[31:24];
      ramp_on = (code != RAMP_CODE_JUMP);
      delay   = (code == RAMP_CODE_DEFAULT) ? effective_delay() : code;
    end
    res.changed = 1'b0;
    if (ticks > delay) begin
      ticks = 8'd0;
      if (ramp_on) begin
        if (level < goal) level = level + 8'd1;
        else if (level > goal) level = level - 8'd1;
      end else begin
        level = goal;
      end
      if (goal != 8'd0 && level != 8'd0 && level < min_level) level = min_level;
      nr = scaled_duty(level, w_red);
      ng = scaled_duty(level, w_green);
      nb = scaled_duty(level, w_blue);
      res.changed = (nr != duty_red) || (ng != duty_green) || (nb != duty_blue);
      duty_red   = nr;
      duty_green = ng;
      duty_blue  = nb;
    end
    res.red   = duty_red;
    res.green = duty_green;
    res.blue  = duty_blue;
    return res;
  endfunction

  always @(posedge clk) begin
    duty_res_t want;
    if (!rst_n) begin
      dflt_delay   = DELAY_RST;
      min_level    = MIN_INT_RST;
      goal         = 8'd0;
      level        = 8'd0;
      w_red        = 8'd0;
      w_green      = 8'd0;
      w_blue       = 8'd0;
      ramp_on      = 1'b0;
      delay        = DELAY_RST;
      ticks        = 8'd0;
      duty_red     = 8'd0;
      duty_green   = 8'd0;
      duty_blue    = 8'd0;
      fail_count   = 0;
      checked      = 0;
      changed_seen = 0;
      expected_duties.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_duties.size() == 0) begin
          report_mismatch("result with none pending, red duty", out_tdata[7:0], -1);
        end else begin
          want = expected_duties.pop_front();
          checked++;
          if (out_tuser) changed_seen++;
          if (out_tdata[7:0] !== want.red)
            report_mismatch("red duty", out_tdata[7:0], want.red);
          if (out_tdata[15:8] !== want.green)
            report_mismatch("green duty", out_tdata[15:8], want.green);
          if (out_tdata[23:16] !== want.blue)
            report_mismatch("blue duty", out_tdata[23:16], want.blue);
          if (out_tuser !== want.changed)
            report_mismatch("changed flag", out_tuser, want.changed);
        end
      end
      if (in_tvalid && in_tready)
        expected_duties.push_back(step_dimmer(dim_op_e'(in_tuser), in_tdata));
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEFAULT_DELAY: dflt_delay = cfg_wdata;
          CFG_MIN_INTENSITY: min_level = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = expected_duties.size();
  end

endmodule

@@ verif/testbench.sv @@
// top of the dimmer testbench: clock, reset, stimulus, back-pressure and verdict
`timescale 1ns / 1ps
module testbench;
  import rlrd_pkg::*;
  import rlrd_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES = 12;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [5*LVL_W-1:0]   in_tdata;
  logic                 in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LVL_W-1:0]     cfg_wdata;

  int fail_count, pending, checked, changed_seen;
  int cycles, in_stall_cycles, n_sent;
  int press_req, press_done;
  int hold_left, stall_left, rdy_mode;
  int gap_mode;

  rgb_led_ramp_dimmer #(.DUTY_BITS(8)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  dimmer_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked      (checked),
    .changed_seen (changed_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (in_tvalid && !in_tready) in_stall_cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // gap length: mostly none or short, a few long
  function automatic int pick_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 20) return 8'd255;
    return 8'($urandom());
  endfunction

  // receiver side: random stalls, stall-free stretches and long hold-offs
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    rdy_mode   = 0;
    press_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (press_req != press_done) begin
        press_done = press_req;
        hold_left  = HOLD_CYCLES;
      end
      if (cycles % 64 == 0) rdy_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (rdy_mode != 0 && $urandom_range(0, 99) < 30) stall_left = pick_gap(1);
      end
    end
  end

  task automatic send_item(input dim_op_e op, input logic [39:0] data, input int gap);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    n_sent++;
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_set(input logic [7:0] lvl, input logic [7:0] r, input logic [7:0] g,
                          input logic [7:0] b, input logic [7:0] code, input int gap);
    send_item(OP_SET, {code, b, g, r, lvl}, gap);
  endtask

  task automatic send_tick(input int gap);
    send_item(OP_TICK, {$urandom(), 8'($urandom())}, gap);
  endtask

  task automatic send_random_set(input int gap);
    logic [7:0] lvl, code;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) lvl = 8'd0;
    else if (r < 35) lvl = 8'($urandom_range(1, 40));
    else lvl = 8'($urandom());
    r = $urandom_range(0, 99);
    if (r < 25) code = RAMP_CODE_JUMP;
    else if (r < 40) code = RAMP_CODE_DEFAULT;
    else if (r < 85) code = 8'($urandom_range(1, 6));
    else code = 8'($urandom());
    send_set(lvl, rand_weight(), rand_weight(), rand_weight(), code, gap);
  endtask

  task automatic run_random(input int n, input int tick_pct, input bit no_gaps);
    int gap;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) gap_mode = ($urandom_range(0, 2) == 0) ? 0 : 1;
      gap = no_gaps ? 0 : pick_gap(gap_mode);
      if ($urandom_range(0, 99) < tick_pct) send_tick(gap);
      else send_random_set(gap);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic pressure_burst();
    press_req++;
    run_random(40, 70, 1'b1);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    n_sent          = 0;
    press_req       = 0;
    gap_mode        = 1;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: ignored tick fields, jump, zero goal, single-step ramp,
    // goal below the minimum level, default delay code
    for (int i = 0; i < 6; i++)
      send_item(OP_TICK, (i % 2) ? 40'hFF_FFFF_FFFF : 40'h0, pick_gap(1));
    send_set(8'd255, 8'd255, 8'd255, 8'd255, RAMP_CODE_JUMP, pick_gap(1));
    send_set(8'd0, 8'd0, 8'd0, 8'd0, RAMP_CODE_JUMP, pick_gap(1));
    send_set(8'd200, 8'd255, 8'd128, 8'd1, 8'd1, pick_gap(1));
    send_tick(pick_gap(1));
    send_tick(pick_gap(1));
    send_set(8'd5, 8'd255, 8'd255, 8'd255, RAMP_CODE_JUMP, pick_gap(1));
    send_tick(pick_gap(1));
    send_set(8'd0, 8'd255, 8'd255, 8'd255, RAMP_CODE_JUMP, pick_gap(1));
    send_tick(pick_gap(1));
    send_set(8'd20, 8'd255, 8'd170, 8'd85, RAMP_CODE_DEFAULT, pick_gap(1));
    for (int i = 0; i < 6; i++) send_tick(pick_gap(1));

    settle();
    write_reg(CFG_DEFAULT_DELAY, 8'd0);
    write_reg(CFG_MIN_INTENSITY, 8'd0);
    run_random(300, 70, 1'b0);

    // default delay above its range, longest wait before a step
    settle();
    write_reg(CFG_DEFAULT_DELAY, 8'd255);
    write_reg(CFG_MIN_INTENSITY, 8'd255);
    send_set(8'd128, rand_weight(), rand_weight(), rand_weight(), RAMP_CODE_DEFAULT, 0);
    run_random(258, 100, 1'b0);
    run_random(40, 70, 1'b0);

    settle();
    write_reg(CFG_DEFAULT_DELAY, DELAY_MAX);
    write_reg(CFG_MIN_INTENSITY, 8'd1);
    run_random(130, 70, 1'b0);
    pressure_burst();
    run_random(130, 70, 1'b0);

    settle();
    write_reg(CFG_DEFAULT_DELAY, 8'($urandom_range(0, 254)));
    write_reg(CFG_MIN_INTENSITY, 8'($urandom()));
    run_random(260, 70, 1'b0);
    pressure_burst();

    settle();
    write_reg(CFG_DEFAULT_DELAY, 8'd3);
    write_reg(CFG_MIN_INTENSITY, 8'd40);
    run_random(200, 65, 1'b0);

    settle();
    $display("sent %0d transactions over six register settings, checked %0d results",
             n_sent, checked);
    $display("%0d results flagged a duty change, input stalled %0d cycles under back-pressure",
             changed_seen, in_stall_cycles);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
